### design/mmt_pkg.sv
// shared types, constants and helpers for the meter map table
`default_nettype none
package mmt_pkg;

    localparam int TICK_W = 31;
    localparam int NUM_W = 6;
    localparam int DEN_W = 3;
    localparam int MEAS_W = 17;
    localparam int BEAT_W = 11;
    localparam int STAT_W = 3;
    localparam int OP_W = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
    localparam logic [BEAT_W-1:0] WHOLE_TICKS = 11'd1536;
    localparam logic [NUM_W-1:0] DEFAULT_NUM = 6'd4;
    localparam logic [DEN_W-1:0] DEFAULT_DEN = 3'd2;
    localparam logic [MEAS_W-1:0] DEFAULT_MEAS = 17'd1536;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_DEL = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK2POS = 3'd2;
    localparam logic [OP_W-1:0] OP_POS2TICK = 3'd3;
    localparam logic [OP_W-1:0] OP_SIG = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 3'd2;
    localparam logic [STAT_W-1:0] ST_ILLEGAL = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [TICK_W-1:0] tick;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [TICK_W-1:0] bar;
    } t_entry;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TICK_W-1:0] tick;
        logic [TICK_W-1:0] bar;
        logic [NUM_W-1:0]  beat;
        logic [BEAT_W-1:0] offset;
        logic [NUM_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [MEAS_W-1:0] meas;
    } t_result;

    // ticks per beat for a denominator code
    function automatic logic [BEAT_W-1:0] beat_len(input logic [DEN_W-1:0] den);
        beat_len = WHOLE_TICKS >> den;
    endfunction

    // ticks per measure
    function automatic logic [MEAS_W-1:0] meas_len(input logic [NUM_W-1:0] num,
                                                   input logic [DEN_W-1:0] den);
        meas_len = MEAS_W'(num) * MEAS_W'(beat_len(den));
    endfunction

endpackage
`default_nettype wire

### design/mmt_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module mmt_div
    import mmt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [TICK_W-1:0] i_dividend,
    input  wire logic [MEAS_W-1:0] i_divisor,
    output logic                   o_done,
    output logic [TICK_W-1:0]      o_quot,
    output logic [MEAS_W-1:0]      o_rem
);

    localparam int CNT_W = $clog2(TICK_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [TICK_W-1:0] r_q;
    logic [MEAS_W-1:0] r_rem;
    logic [MEAS_W-1:0] r_dvs;
    logic [MEAS_W:0]   trial;
    logic              fits;

    // trial subtract of the shifted partial remainder
    assign trial = {r_rem, r_q[TICK_W-1]};
    assign fits = trial >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TICK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_start) begin
            r_q <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[TICK_W-2:0], fits};
            r_rem <= fits ? MEAS_W'(trial - {1'b0, r_dvs}) : trial[MEAS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem = r_rem;

endmodule
`default_nettype wire

### design/meter_map_table_unit.sv
// meter map table: sorted signature table with renumbering and position queries
// queries scan the table entry by entry, and tick to position then runs two divides;
// edits add a shift pass and then a renumber pass over every entry, one divide per
// entry on the 31-step divider
// one item at a time: busy is high from the transfer until the result strobe
// synchronous active-low reset empties the table; results cannot be stalled
`default_nettype none
module meter_map_table_unit
    import mmt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [TICK_W-1:0] i_key_tick,
    input  wire logic [NUM_W-1:0]  i_numerator,
    input  wire logic [DEN_W-1:0]  i_denom_code,
    input  wire logic [TICK_W-1:0] i_bar_number,
    input  wire logic [NUM_W-1:0]  i_beat_number,
    output logic                   o_valid,
    output logic [STAT_W-1:0]      o_status,
    output logic [TICK_W-1:0]      o_result_tick,
    output logic [TICK_W-1:0]      o_bar_out,
    output logic [NUM_W-1:0]       o_beat_out,
    output logic [BEAT_W-1:0]      o_offset_out,
    output logic [NUM_W-1:0]       o_numerator_out,
    output logic [DEN_W-1:0]       o_denom_code_out,
    output logic [MEAS_W-1:0]      o_measure_ticks
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W = TICK_W + MEAS_W;
    localparam int SUM_W = PROD_W + 2;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_SC_RD = 5'd2;
    localparam logic [4:0] S_SC_CHK = 5'd3;
    localparam logic [4:0] S_EDIT = 5'd4;
    localparam logic [4:0] S_SH_RD = 5'd5;
    localparam logic [4:0] S_SH_WR = 5'd6;
    localparam logic [4:0] S_DL_RD = 5'd7;
    localparam logic [4:0] S_DL_WR = 5'd8;
    localparam logic [4:0] S_RN_RD = 5'd9;
    localparam logic [4:0] S_RN_DIV = 5'd10;
    localparam logic [4:0] S_RN_WAIT = 5'd11;
    localparam logic [4:0] S_Q2_WAIT1 = 5'd12;
    localparam logic [4:0] S_Q2_WAIT2 = 5'd13;
    localparam logic [4:0] S_Q3_MUL = 5'd14;
    localparam logic [4:0] S_Q3_ADD = 5'd15;

    logic [4:0]        r_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_pos;
    logic [AW-1:0]     r_e;
    logic              r_found;
    t_entry            r_ent;
    t_entry            r_rd;
    t_result           r_res;
    logic              r_valid;

    // latched request
    logic [OP_W-1:0]   r_op;
    logic [TICK_W-1:0] r_key;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [TICK_W-1:0] r_barn;
    logic [NUM_W-1:0]  r_beatn;

    // renumber and query working registers
    logic [TICK_W-1:0] r_prev;
    logic [TICK_W-1:0] r_bar;
    logic [MEAS_W-1:0] r_tm;
    logic [PROD_W-1:0] r_prod;
    logic [MEAS_W-1:0] r_bt;

    t_entry            mem [TABLE_DEPTH];
    logic              mem_re;
    logic [AW-1:0]     mem_ra;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    t_entry            mem_wd;

    logic              div_start;
    logic [TICK_W-1:0] div_dvd;
    logic [MEAS_W-1:0] div_dvs;
    logic              div_done;
    logic [TICK_W-1:0] div_q;
    logic [MEAS_W-1:0] div_r;

    logic              accept;
    logic              hit;
    logic              match;
    logic [TICK_W-1:0] new_bar;
    logic [SUM_W-1:0]  sum;
    t_result           res_miss;
    t_result           res_sig;
    t_result           res_illegal;
    t_result           res_full;
    t_result           res_absent;

    assign accept = start && !busy;
    assign busy = (r_state != S_IDLE);
    assign hit = (r_op == OP_POS2TICK) ? (r_rd.bar <= r_barn) : (r_rd.tick <= r_key);
    assign match = r_found && (r_ent.tick == r_key);
    assign new_bar = r_bar + div_q;
    assign sum = SUM_W'(r_ent.tick) + SUM_W'(r_prod) + SUM_W'(r_bt) + SUM_W'(r_key);

    // canned results for a missing entry, the entry in force and the error codes
    always_comb begin
        res_miss = '0;
        res_miss.status = ST_NOT_FOUND;
        res_miss.num = DEFAULT_NUM;
        res_miss.den = DEFAULT_DEN;
        res_miss.meas = DEFAULT_MEAS;
        res_sig = '0;
        res_sig.status = ST_OK;
        res_sig.num = r_ent.num;
        res_sig.den = r_ent.den;
        res_sig.meas = meas_len(r_ent.num, r_ent.den);
        res_illegal = '0;
        res_illegal.status = ST_ILLEGAL;
        res_full = '0;
        res_full.status = ST_FULL;
        res_absent = '0;
        res_absent.status = ST_NOT_FOUND;
    end

    // memory port and divider control
    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_idx[AW-1:0];
        mem_we = 1'b0;
        mem_wa = r_idx[AW-1:0];
        mem_wd = r_rd;
        div_start = 1'b0;
        div_dvd = r_key - r_ent.tick;
        div_dvs = meas_len(r_ent.num, r_ent.den);
        case (r_state)
            S_SC_RD: begin
                mem_re = (r_idx != r_count);
            end
            S_EDIT: begin
                if (r_op == OP_ADD && match) begin
                    mem_we = 1'b1;
                    mem_wa = r_e;
                    mem_wd = '{tick: r_key, num: r_num, den: r_den, bar: r_ent.bar};
                end
                if ((r_op == OP_TICK2POS) && r_found) begin
                    div_start = 1'b1;
                end
            end
            S_SH_RD: begin
                if (r_idx == r_pos) begin
                    mem_we = 1'b1;
                    mem_wa = r_pos[AW-1:0];
                    mem_wd = '{tick: r_key, num: r_num, den: r_den, bar: '0};
                end else begin
                    mem_re = 1'b1;
                    mem_ra = AW'(r_idx - 1'b1);
                end
            end
            S_SH_WR, S_DL_WR: begin
                mem_we = 1'b1;
            end
            S_DL_RD: begin
                if (CW'(r_idx + 1'b1) < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = AW'(r_idx + 1'b1);
                end
            end
            S_RN_RD: begin
                mem_re = (r_idx != r_count);
            end
            S_RN_DIV: begin
                div_start = 1'b1;
                div_dvd = r_rd.tick - r_prev;
                div_dvs = r_tm;
            end
            S_RN_WAIT: begin
                if (div_done) begin
                    mem_we = 1'b1;
                    mem_wd = '{tick: r_rd.tick, num: r_rd.num, den: r_rd.den, bar: new_bar};
                end
            end
            S_Q2_WAIT1: begin
                div_start = div_done;
                div_dvd = TICK_W'(div_r);
                div_dvs = MEAS_W'(beat_len(r_ent.den));
            end
            default: begin
            end
        endcase
    end

    // table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // shared divider
    mmt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    // sequencer control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if ((r_op == OP_ADD && r_num == '0) || r_op > OP_SIG) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: begin
                    r_state <= (r_idx == r_count) ? S_EDIT : S_SC_CHK;
                end
                S_SC_CHK: begin
                    r_state <= hit ? S_SC_RD : S_EDIT;
                end
                S_EDIT: begin
                    case (r_op)
                        OP_ADD: begin
                            if (match) begin
                                r_state <= S_RN_RD;
                            end else if (r_count == CW'(TABLE_DEPTH)) begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_state <= S_SH_RD;
                            end
                        end
                        OP_DEL: begin
                            if (match) begin
                                r_state <= S_DL_RD;
                            end else begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        OP_TICK2POS: begin
                            if (r_found) begin
                                r_state <= S_Q2_WAIT1;
                            end else begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        OP_POS2TICK: begin
                            if (r_found) begin
                                r_state <= S_Q3_MUL;
                            end else begin
                                r_valid <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_valid <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_SH_RD: begin
                    if (r_idx == r_pos) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_RN_RD;
                    end else begin
                        r_state <= S_SH_WR;
                    end
                end
                S_SH_WR: begin
                    r_state <= S_SH_RD;
                end
                S_DL_RD: begin
                    if (CW'(r_idx + 1'b1) < r_count) begin
                        r_state <= S_DL_WR;
                    end else begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_RN_RD;
                    end
                end
                S_DL_WR: begin
                    r_state <= S_DL_RD;
                end
                S_RN_RD: begin
                    if (r_idx == r_count) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_RN_DIV;
                    end
                end
                S_RN_DIV: begin
                    r_state <= S_RN_WAIT;
                end
                S_RN_WAIT: begin
                    if (div_done) begin
                        r_state <= S_RN_RD;
                    end
                end
                S_Q2_WAIT1: begin
                    if (div_done) begin
                        r_state <= S_Q2_WAIT2;
                    end
                end
                S_Q2_WAIT2: begin
                    if (div_done) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_Q3_MUL: begin
                    r_state <= S_Q3_ADD;
                end
                S_Q3_ADD: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_op <= i_opcode;
                    r_key <= i_key_tick;
                    r_num <= i_numerator;
                    r_den <= i_denom_code;
                    r_barn <= i_bar_number;
                    r_beatn <= i_beat_number;
                end
            end
            S_DECODE: begin
                r_idx <= '0;
                r_found <= 1'b0;
                r_res <= (r_op == OP_ADD && r_num == '0) ? res_illegal : '0;
            end
            S_SC_CHK: begin
                if (hit) begin
                    r_found <= 1'b1;
                    r_e <= r_idx[AW-1:0];
                    r_ent <= r_rd;
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_EDIT: begin
                // renumber pass starts from bar 0 in 4/4
                r_prev <= '0;
                r_bar <= '0;
                r_tm <= DEFAULT_MEAS;
                case (r_op)
                    OP_ADD: begin
                        if (match) begin
                            r_idx <= '0;
                            r_res <= '0;
                        end else begin
                            r_idx <= r_count;
                            r_pos <= r_found ? CW'(r_e) + 1'b1 : '0;
                            r_res <= (r_count == CW'(TABLE_DEPTH)) ? res_full : '0;
                        end
                    end
                    OP_DEL: begin
                        r_idx <= CW'(r_e);
                        r_res <= match ? '0 : res_absent;
                    end
                    OP_TICK2POS, OP_SIG, OP_POS2TICK: begin
                        r_res <= r_found ? res_sig : res_miss;
                    end
                    default: begin
                        r_res <= '0;
                    end
                endcase
            end
            S_SH_RD: begin
                if (r_idx == r_pos) begin
                    r_idx <= '0;
                end
            end
            S_SH_WR: begin
                r_idx <= r_idx - 1'b1;
            end
            S_DL_RD: begin
                if (!(CW'(r_idx + 1'b1) < r_count)) begin
                    r_idx <= '0;
                end
            end
            S_DL_WR: begin
                r_idx <= r_idx + 1'b1;
            end
            S_RN_WAIT: begin
                if (div_done) begin
                    r_bar <= new_bar;
                    r_prev <= r_rd.tick;
                    r_tm <= meas_len(r_rd.num, r_rd.den);
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_Q2_WAIT1: begin
                if (div_done) begin
                    r_res.bar <= r_ent.bar + div_q;
                end
            end
            S_Q2_WAIT2: begin
                if (div_done) begin
                    r_res.beat <= div_q[NUM_W-1:0];
                    r_res.offset <= div_r[BEAT_W-1:0];
                end
            end
            S_Q3_MUL: begin
                r_prod <= PROD_W'(r_barn - r_ent.bar) * PROD_W'(r_res.meas);
                r_bt <= MEAS_W'(beat_len(r_ent.den)) * MEAS_W'(r_beatn);
            end
            S_Q3_ADD: begin
                if (sum > SUM_W'(TICK_MAX)) begin
                    r_res.status <= ST_OVERFLOW;
                    r_res.tick <= TICK_MAX;
                end else begin
                    r_res.tick <= sum[TICK_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // result ports
    assign o_valid = r_valid;
    assign o_status = r_res.status;
    assign o_result_tick = r_res.tick;
    assign o_bar_out = r_res.bar;
    assign o_beat_out = r_res.beat;
    assign o_offset_out = r_res.offset;
    assign o_numerator_out = r_res.num;
    assign o_denom_code_out = r_res.den;
    assign o_measure_ticks = r_res.meas;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held for two cycles");

    a_transfer_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy && !r_valid)
        else $error("busy not raised after transfer");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RN_WAIT || r_state == S_Q2_WAIT1
                      || r_state == S_Q2_WAIT2))
        else $error("divider finished with no consumer");

endmodule
`default_nettype wire
